@@ rtl/assert_macros.svh @@
// assertion helpers for the checker file
// every property is sampled on the rising edge of clk and is off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define PFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfm assertion failed");

// property holds in the cycle after
`define PFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfm assertion failed");

`endif

@@ rtl/pfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_pkg
// constants, types and the cosine rom contents of the pixel fm tone generator
// ----------------------------------------------------------------------------
package pfm_pkg;

    localparam int PIXEL_SAMPLE_COUNT = 8;
    localparam int COS_TABLE_BITS    = 10;
    localparam int COS_SIZE          = 1 << COS_TABLE_BITS;
    localparam int CNT_W             = (PIXEL_SAMPLE_COUNT > 1) ?
                                       $clog2(PIXEL_SAMPLE_COUNT) : 1;

    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 40;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_STEP = 2'd1;

    localparam logic [31:0] CENTER_STEP_RST    = 32'h2000_0000;
    localparam logic [30:0] DEVIATION_STEP_RST = 31'h2000_0000;

    // step request handed from the front end to the sample generator
    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic               last;
    } step_req_t;

    typedef logic signed [SAMPLE_W-1:0] cos_rom_t [COS_SIZE];

    // fixed point taylor series, q30
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam longint unsigned COS_DIV [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned SIN_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   mag;
        longint signed     sum;
        int unsigned       q;
        int unsigned       r;
        logic              use_sin;
        logic              neg;
        logic [15:0]       mag16;
        for (int k = 0; k < COS_SIZE; k++)
        begin
            q = (k >> (COS_TABLE_BITS - 2)) & 3;
            r = k & ((1 << (COS_TABLE_BITS - 2)) - 1);
            x = (longint'(r) * TWO_PI_Q30) >> COS_TABLE_BITS;
            x2 = (x * x) >> 30;
            use_sin = (q == 1) || (q == 3);
            neg = (q == 1) || (q == 2);
            t = use_sin ? x : ONE_Q30;
            sum = 0;
            for (int n = 0; n < 10; n++)
            begin
                if (n % 2 == 1)
                begin
                    sum = sum - longint'(t);
                end
                else
                begin
                    sum = sum + longint'(t);
                end
                if (use_sin)
                begin
                    t = ((t * x2) >> 30) / SIN_DIV[n];
                end
                else
                begin
                    t = ((t * x2) >> 30) / COS_DIV[n];
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > longint'(ONE_Q30))
            begin
                sum = longint'(ONE_Q30);
            end
            mag = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
            mag16 = mag[15:0];
            rom[k] = neg ? $signed(-mag16) : $signed(mag16);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

@@ rtl/pixel_fm_tone_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_fm_tone_generator
// frequency modulates an 8-bit pixel stream onto a cosine tone
// ----------------------------------------------------------------------------
// Each accepted pixel request sets a phase step of
// center_step + floor(deviation_step * (pixel - 128) / 256), modulo 2^32, and
// produces PIXEL_SAMPLE_COUNT (8) signed 16-bit cosine samples read from a
// 1024-entry rom at the top 10 bits of a 32-bit phase accumulator that
// advances by the step after each sample. The phase carries on from pixel to
// pixel and is cleared only by reset. Throughput is one sample per cycle
// while out_stall is low, set by the single rom read port; a following
// pixel is taken into the input stage while the current one is still
// producing samples, so the sample stream has no gaps. The first sample of
// a pixel passes the multiply register, the generator load and the rom read
// in that order. last_of_pixel marks the
// final sample of each pixel and block_end marks it also when the pixel came
// with last_in_block. Register 0 is center_step, register 1 deviation_step
// (31 bits, upper data bit ignored); other indexes are ignored. cfg_ready is
// always high, and registers are to be written only while no pixel is in
// flight.
// ----------------------------------------------------------------------------
module pixel_fm_tone_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    // pixel requests
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      pixel,
    input  logic                            last_in_block,
    // sample requests
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              sample,
    output logic                            last_of_pixel,
    output logic                            block_end
);
    import pfm_pkg::*;

    logic [31:0]              center_reg;
    logic [30:0]              deviation_reg;
    logic                     a_valid_reg;
    logic                     a_valid_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     a_last_reg;
    logic                     in_accept;
    logic                     gen_ready;
    logic                     gen_load;
    logic signed [8:0]        pix_offset;
    logic signed [PROD_W:0]   prod_full;
    step_req_t                req;

    // config write port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= CENTER_STEP_RST;
            deviation_reg <= DEVIATION_STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_STEP:    center_reg    <= cfg_data;
                REG_DEVIATION_STEP: deviation_reg <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    // input stage: the deviation multiply, registered before the step add
    assign in_accept  = in_valid && !in_stall;
    assign gen_load   = a_valid_reg && gen_ready;
    assign in_stall   = a_valid_reg && !gen_ready;

    // pixel - 128 as a signed 9-bit value, range -128..127
    assign pix_offset = $signed({1'b0, pixel}) - 9'sd128;
    assign prod_full  = $signed({1'b0, deviation_reg}) * pix_offset;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (gen_load)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prod_reg   <= prod_full[PROD_W-1:0];
            a_last_reg <= last_in_block;
        end
    end

    // floor of the product over 256 is an arithmetic shift, kept mod 2^32
    assign req.step = center_reg + prod_reg[PROD_W-1:8];
    assign req.last = a_last_reg;

    pfm_sample_gen u_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (gen_load),
        .req           (req),
        .gen_ready     (gen_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .last_of_pixel (last_of_pixel),
        .block_end     (block_end)
    );

endmodule

@@ rtl/pfm_sample_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_sample_gen
// phase accumulator, cosine rom and output register
// ----------------------------------------------------------------------------
module pfm_sample_gen (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  pfm_pkg::step_req_t    req,
    output logic                  gen_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    sample,
    output logic                  last_of_pixel,
    output logic                  block_end
);
    import pfm_pkg::*;

    logic                 gen_valid_reg;
    logic                 gen_valid_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [PHASE_W-1:0]   step_reg;
    logic                 gen_last_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                 lop_reg;
    logic                 bend_reg;
    logic                 issue;
    logic                 count_last;

    // one rom read per cycle while the output register is free or draining
    assign issue      = gen_valid_reg && (!out_valid_reg || !out_stall);
    assign count_last = (count_reg == CNT_W'(PIXEL_SAMPLE_COUNT - 1));
    assign gen_ready  = !gen_valid_reg || (issue && count_last);

    always_comb
    begin
        gen_valid_next = gen_valid_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            phase_next = phase_reg + step_reg;
            count_next = count_reg + CNT_W'(1);
            if (count_last)
            begin
                gen_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            gen_valid_next = 1'b1;
            count_next     = '0;
        end
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_valid_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_valid_reg <= gen_valid_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // step payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg     <= req.step;
            gen_last_reg <= req.last;
        end
    end

    // synchronous rom read, data register doubles as the output register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            sample_reg <= COS_ROM[phase_reg[PHASE_W-1 -: COS_TABLE_BITS]];
            lop_reg    <= count_last;
            bend_reg   <= count_last && gen_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign last_of_pixel = lop_reg;
    assign block_end     = bend_reg;

endmodule

@@ rtl/pfm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_checker
// port level checks of the pixel fm tone generator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [7:0]                      pixel,
    input  logic                            last_in_block,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [15:0]              sample,
    input  logic                            last_of_pixel,
    input  logic                            block_end
);

    logic [8:0]  in_word;
    logic [17:0] out_word;

    assign in_word  = {pixel, last_in_block};
    assign out_word = {sample, last_of_pixel, block_end};

    // a stalled pixel request holds
    `PFM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))

    // a stalled sample request holds
    `PFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // block end only on the last sample of a pixel
    `PFM_ASSERT_NOW(a_bend_last, out_valid && block_end, last_of_pixel)

    // rom never holds the most negative code
    `PFM_ASSERT_NOW(a_sample_range, out_valid, sample != 16'sh8000)

    // samples of one pixel follow without a gap
    `PFM_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last_of_pixel, out_valid)

endmodule

bind pixel_fm_tone_generator pfm_checker u_pfm_checker (.*);

@@ sim/pixel_fm_tone_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_fm_tone_generator_tb
// self-checking bench for the pixel fm tone generator
// ----------------------------------------------------------------------------
// Pixel requests go in with random gaps and samples are taken with random
// stalls. A scoreboard keeps its own cosine rom, step registers and phase
// accumulator, turns every accepted pixel into the samples it must produce,
// and compares each accepted sample field by field with the oldest one
// waiting. The step registers are rewritten between phases, only once every
// expected sample has come out, and cover the extremes of both.
// ----------------------------------------------------------------------------
module pixel_fm_tone_generator_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned REPORT_CAP  = 100;

    // indexes with no register behind them, writes there must be dropped
    localparam logic [pfm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [pfm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last_of_pixel;
        logic               block_end;
    } tone_sample_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the samples of each pixel and checks them in order
    // ------------------------------------------------------------------------
    class fm_sample_board;
        logic signed [15:0] cos_rom [pfm_pkg::COS_SIZE];
        logic [31:0]        center_step;
        logic [30:0]        deviation_step;
        logic [31:0]        phase_acc;
        tone_sample_t       expected_samples [$];
        int unsigned        mismatches;

        // alternating taylor sum in q30, clamped to 0..1
        function longint signed series_q30(longint unsigned t0, longint unsigned x2,
                                           longint unsigned k0);
            longint signed   acc;
            longint unsigned t;
            longint unsigned k;
            acc = 0;
            t = t0;
            k = k0;
            for (int n = 0; n < 10; n++)
            begin
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(t);
                end
                else
                begin
                    acc = acc + longint'(t);
                end
                t = ((t * x2) >> 30) / ((k + 1) * (k + 2));
                k = k + 2;
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > longint'(pfm_pkg::ONE_Q30))
            begin
                acc = longint'(pfm_pkg::ONE_Q30);
            end
            return acc;
        endfunction

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned m;
            longint unsigned mag;
            int unsigned     q;
            int unsigned     r;
            center_step    = pfm_pkg::CENTER_STEP_RST;
            deviation_step = pfm_pkg::DEVIATION_STEP_RST;
            phase_acc      = '0;
            mismatches     = 0;
            for (int k = 0; k < pfm_pkg::COS_SIZE; k++)
            begin
                q = (k >> (pfm_pkg::COS_TABLE_BITS - 2)) & 3;
                r = k & ((1 << (pfm_pkg::COS_TABLE_BITS - 2)) - 1);
                x = (longint'(r) * pfm_pkg::TWO_PI_Q30) >> pfm_pkg::COS_TABLE_BITS;
                x2 = (x * x) >> 30;
                // even quadrants use the cosine series, odd ones the sine series
                if (q == 0 || q == 2)
                begin
                    m = series_q30(pfm_pkg::ONE_Q30, x2, 0);
                end
                else
                begin
                    m = series_q30(x, x2, 1);
                end
                mag = (m * 32767 + (64'd1 << 29)) >> 30;
                cos_rom[k] = (q == 1 || q == 2) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
            end
        endfunction

        function void write_reg(logic [pfm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                pfm_pkg::REG_CENTER_STEP:    center_step = data;
                pfm_pkg::REG_DEVIATION_STEP: deviation_step = data[30:0];
                default: ;
            endcase
        endfunction

        // accepted pixel request: queue its samples and advance the phase
        function void take_pixel(logic [7:0] pix, logic last_blk);
            longint signed prod;
            int            pix_off;
            logic [31:0]   step;
            tone_sample_t  s;
            pix_off = int'(pix) - 128;
            prod = longint'(deviation_step) * longint'(pix_off);
            // low word of the floored shift by 8
            step = center_step + prod[39:8];
            for (int j = 0; j < pfm_pkg::PIXEL_SAMPLE_COUNT; j++)
            begin
                s.value         = cos_rom[phase_acc[31 -: pfm_pkg::COS_TABLE_BITS]];
                s.last_of_pixel = (j == pfm_pkg::PIXEL_SAMPLE_COUNT - 1);
                s.block_end     = s.last_of_pixel && last_blk;
                expected_samples.push_back(s);
                phase_acc = phase_acc + step;
            end
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_sample(logic signed [15:0] val, logic lop, logic bend);
            tone_sample_t want;
            if (expected_samples.size() == 0)
            begin
                flag("unexpected sample, pending count", 0, 1);
                return;
            end
            want = expected_samples.pop_front();
            if (val !== want.value)
            begin
                flag("sample", want.value, val);
            end
            if (lop !== want.last_of_pixel)
            begin
                flag("last_of_pixel", want.last_of_pixel, lop);
            end
            if (bend !== want.block_end)
            begin
                flag("block_end", want.block_end, bend);
            end
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]                     cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      pixel;
    logic                            last_in_block;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [15:0]              sample;
    logic                            last_of_pixel;
    logic                            block_end;

    fm_sample_board board;
    int unsigned    cycle_count = 0;
    // while set, neither side idles
    bit             calm = 1'b0;

    // pixels at the edges of the range and around the center value
    bit [7:0] corner_pixels [10] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd129,
                                     8'd1, 8'd254, 8'h55, 8'hAA, 8'd64};

    pixel_fm_tone_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .last_in_block (last_in_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .last_of_pixel (last_of_pixel),
        .block_end     (block_end)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // monitors: both look at the values that held just before the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            board.take_pixel(pixel, last_in_block);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_sample(sample, last_of_pixel, block_end);
        end
    end

    // sample receiver: random stalls, plus one long hold-off partway through
    // the random part so the pipeline fills and pushes back on the pixel side
    initial
    begin
        int unsigned samples_taken;
        int unsigned hold_left;
        bit          pressure_done;
        samples_taken = 0;
        hold_left = 0;
        pressure_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                samples_taken++;
            end
            if (!pressure_done && samples_taken >= 1500)
            begin
                hold_left = 300;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 34);
            end
        end
    end

    // register write, the channel drops valid for a cycle after each write
    task automatic write_register(input logic [pfm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    // one pixel request, with random idle cycles ahead of it
    task automatic offer_pixel(input logic [7:0] pix, input logic last_blk);
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pixel         <= pix;
        last_in_block <= last_blk;
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering and let every predicted sample come out, then keep
    // idling so the generator is surely quiet
    task automatic wait_for_samples();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] pix;
        board = new();
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= pfm_pkg::REG_CENTER_STEP;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        pixel         <= '0;
        last_in_block <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner pixels with the reset step settings
        for (int i = 0; i < 10; i++)
        begin
            offer_pixel(corner_pixels[i], (i % 3 == 2));
        end
        wait_for_samples();

        // largest steps, so the step sum wraps; bit 31 of the deviation data
        // must be dropped and the spare indexes must change nothing
        write_register(pfm_pkg::REG_CENTER_STEP, 32'hFFFF_FFFF);
        write_register(pfm_pkg::REG_DEVIATION_STEP, 32'hFFFF_FFFF);
        write_register(REG_SPARE_2, $urandom());
        write_register(REG_SPARE_3, $urandom());
        for (int i = 0; i < 10; i++)
        begin
            offer_pixel(corner_pixels[i], (i % 2 == 0));
        end
        wait_for_samples();

        // random part, five phases with their own step settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    write_register(pfm_pkg::REG_CENTER_STEP, 32'h0);
                    write_register(pfm_pkg::REG_DEVIATION_STEP, 32'h0);
                    write_register(REG_SPARE_2, $urandom());
                end
                2:
                begin
                    write_register(pfm_pkg::REG_CENTER_STEP, $urandom());
                    write_register(pfm_pkg::REG_DEVIATION_STEP, 32'h7FFF_FFFF);
                end
                3:
                begin
                    write_register(pfm_pkg::REG_CENTER_STEP, 32'h8000_0000);
                    write_register(pfm_pkg::REG_DEVIATION_STEP, $urandom());
                end
                default:
                begin
                    write_register(pfm_pkg::REG_CENTER_STEP, $urandom());
                    write_register(pfm_pkg::REG_DEVIATION_STEP, $urandom());
                end
            endcase
            for (int i = 0; i < 100; i++)
            begin
                // a back-to-back stretch in the middle of one phase
                calm = (ph == 3) && (i >= 10) && (i < 90);
                if ($urandom_range(7) == 0)
                begin
                    pix = corner_pixels[$urandom_range(9)];
                end
                else
                begin
                    pix = $urandom_range(255);
                end
                offer_pixel(pix, ($urandom_range(15) == 0));
            end
            calm = 1'b0;
            wait_for_samples();
        end

        if (board.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfm_pkg.sv
rtl/pfm_sample_gen.sv
rtl/pixel_fm_tone_generator.sv
rtl/pfm_checker.sv
sim/pixel_fm_tone_generator_tb.sv
